// ----- hdl/rgbwc_pkg.sv -----
package rgbwc_pkg;

    // Default geometry and number format
    localparam int MAX_IMAGE_WIDTH = 2048;
    localparam int MAX_KERNEL      = 5;
    localparam int COEF_FRAC_BITS  = 8;

    // Fixed field widths
    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int COEF_W  = 12;
    localparam int CFG_W   = 60;
    localparam int IDX_W   = 3;
    localparam int KDIM_W  = 3;
    localparam int IMGW_W  = 12;
    localparam int ROW_W   = 16;
    localparam int PROD_W  = CH_W + 1 + COEF_W;
    localparam int SUM_W   = PROD_W + 7;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [IDX_W-1:0] REG_COEF_ROW0     = 3'd3;
    localparam logic [IDX_W-1:0] REG_COEF_ROW1     = 3'd4;
    localparam logic [IDX_W-1:0] REG_COEF_ROW2     = 3'd5;
    localparam logic [IDX_W-1:0] REG_COEF_ROW3     = 3'd6;
    localparam logic [IDX_W-1:0] REG_COEF_ROW4     = 3'd7;

    // Reset values
    localparam logic [KDIM_W-1:0] KERNEL_DIM_RESET  = 3'd3;
    localparam logic [IMGW_W-1:0] IMAGE_WIDTH_RESET = 12'd640;
    localparam logic [CFG_W-1:0]  COEF_ROW1_RESET   = 60'd1048576;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // Per-cycle control handed to every window cell
    typedef struct packed {
        logic shift;    // take the neighbour's pixel
        logic advance;  // register a fresh product
    } cell_ctrl_t;

endpackage

// ----- hdl/rgbwc_ram.sv -----
module rgbwc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rgbwc_cell.sv -----
module rgbwc_cell (
    input  logic                                    aclk,
    input  rgbwc_pkg::cell_ctrl_t                   ctrl,
    input  logic [rgbwc_pkg::PIX_W-1:0]             pix_in,
    input  logic signed [rgbwc_pkg::COEF_W-1:0]     weight,
    output logic [rgbwc_pkg::PIX_W-1:0]             pix_out,
    output logic signed [rgbwc_pkg::PROD_W-1:0]     prod_r,
    output logic signed [rgbwc_pkg::PROD_W-1:0]     prod_g,
    output logic signed [rgbwc_pkg::PROD_W-1:0]     prod_b
);

    localparam int CW = rgbwc_pkg::CH_W;

    logic [rgbwc_pkg::PIX_W-1:0]         pix_reg;
    logic signed [rgbwc_pkg::PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            pix_reg <= pix_in;
        end
        if (ctrl.advance) begin
            prod_r_reg <= $signed({1'b0, pix_reg[3*CW-1:2*CW]}) * weight;
            prod_g_reg <= $signed({1'b0, pix_reg[2*CW-1:CW]}) * weight;
            prod_b_reg <= $signed({1'b0, pix_reg[CW-1:0]}) * weight;
        end
    end

    assign pix_out = pix_reg;
    assign prod_r  = prod_r_reg;
    assign prod_g  = prod_g_reg;
    assign prod_b  = prod_b_reg;

endmodule

// ----- hdl/rgb_window_convolution.sv -----
// Channel   | Direction | Ports
// ----------+-----------+-----------------------------------------------------
// s_        | in        | s_valid/s_ready, red/green/blue_in, frame_end_in
// m_        | out       | m_valid/m_ready, red/green/blue_out, frame_end_out
// cfg_      | in        | cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// One pixel request per clock unless stalled; the rate is set by the single
// pipeline step of the window cell chain and the one line RAM port pair.
// A result is registered in stage A, the window cell, the cell products, the
// per-row sums and the output register before it is presented.
// Reset (aresetn low, synchronous) clears counters, pipeline valids and
// config registers; line RAM and window data stay undefined until written.
// A stalled result holds the whole pipeline and drops s_ready.
module rgb_window_convolution #(
    parameter int MAX_IMAGE_WIDTH = rgbwc_pkg::MAX_IMAGE_WIDTH,
    parameter int MAX_KERNEL      = rgbwc_pkg::MAX_KERNEL,
    parameter int COEF_FRAC_BITS  = rgbwc_pkg::COEF_FRAC_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rgbwc_pkg::CH_W-1:0]        s_red_in,
    input  logic [rgbwc_pkg::CH_W-1:0]        s_green_in,
    input  logic [rgbwc_pkg::CH_W-1:0]        s_blue_in,
    input  logic                              s_frame_end_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rgbwc_pkg::CH_W-1:0]        m_red_out,
    output logic [rgbwc_pkg::CH_W-1:0]        m_green_out,
    output logic [rgbwc_pkg::CH_W-1:0]        m_blue_out,
    output logic                              m_frame_end_out,
    input  logic                              cfg_wr_en,
    input  logic [rgbwc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [rgbwc_pkg::CFG_W-1:0]       cfg_wdata
);

    localparam int PIX_W  = rgbwc_pkg::PIX_W;
    localparam int CH_W   = rgbwc_pkg::CH_W;
    localparam int COEF_W = rgbwc_pkg::COEF_W;
    localparam int PROD_W = rgbwc_pkg::PROD_W;
    localparam int SUM_W  = rgbwc_pkg::SUM_W;
    localparam int KDIM_W = rgbwc_pkg::KDIM_W;
    localparam int IMGW_W = rgbwc_pkg::IMGW_W;
    localparam int ROW_W  = rgbwc_pkg::ROW_W;
    localparam int IDX_W  = rgbwc_pkg::IDX_W;
    localparam int COL_W  = $clog2(MAX_IMAGE_WIDTH);
    localparam int CMP_W  = (COL_W + 1 > IMGW_W) ? COL_W + 1 : IMGW_W;
    localparam int KI_W   = $clog2(MAX_KERNEL);
    localparam int ROWC_W = MAX_KERNEL * COEF_W;
    localparam int LINE_W = (MAX_KERNEL - 1) * PIX_W;
    localparam logic [KDIM_W-1:0] KMAX_DIM = KDIM_W'(MAX_KERNEL);
    localparam logic [CMP_W-1:0]  W_MAX    = CMP_W'(MAX_IMAGE_WIDTH);
    localparam logic [CMP_W-1:0]  W_MIN    = CMP_W'(2);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [KDIM_W-1:0] kernel_width_reg, kernel_height_reg;
    logic [IMGW_W-1:0] image_width_reg;
    logic [ROWC_W-1:0] coef_reg [MAX_KERNEL];
    logic [IDX_W-1:0]  coef_sel;

    assign coef_sel = cfg_index - rgbwc_pkg::REG_COEF_ROW0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_width_reg  <= rgbwc_pkg::KERNEL_DIM_RESET;
            kernel_height_reg <= rgbwc_pkg::KERNEL_DIM_RESET;
            image_width_reg   <= rgbwc_pkg::IMAGE_WIDTH_RESET;
            for (int i = 0; i < MAX_KERNEL; i++) begin
                coef_reg[i] <= (i == 1) ? rgbwc_pkg::COEF_ROW1_RESET[ROWC_W-1:0] : '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rgbwc_pkg::REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_wdata[KDIM_W-1:0];
                rgbwc_pkg::REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_wdata[KDIM_W-1:0];
                rgbwc_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_wdata[IMGW_W-1:0];
                default: begin
                    // coefficient rows; drop rows beyond the window
                    if (32'(coef_sel) < MAX_KERNEL) begin
                        coef_reg[coef_sel[KI_W-1:0]] <= cfg_wdata[ROWC_W-1:0];
                    end
                end
            endcase
        end
    end

    // Saturate kernel dimensions and image width
    logic [KDIM_W-1:0] kw_sat, kh_sat;
    logic [CMP_W-1:0]  width_sat;

    always_comb begin
        kw_sat    = (kernel_width_reg > KMAX_DIM) ? KMAX_DIM : kernel_width_reg;
        kh_sat    = (kernel_height_reg > KMAX_DIM) ? KMAX_DIM : kernel_height_reg;
        width_sat = CMP_W'(image_width_reg);
        if (width_sat < W_MIN) width_sat = W_MIN;
        if (width_sat > W_MAX) width_sat = W_MAX;
    end

    // ------------------------------------------------------------------
    // Flow control: every stage advances unless the output is stalled
    // ------------------------------------------------------------------
    logic adv, accept;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Column and row counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [CMP_W-1:0] col_inc;
    logic             emit;

    always_comb begin
        col_inc  = CMP_W'(col_reg) + CMP_W'(1);
        col_next = col_inc[COL_W-1:0];
        row_next = row_reg;
        if (s_frame_end_in) begin
            col_next = '0;
            row_next = '0;
        end else if (col_inc >= width_sat) begin
            col_next = '0;
            if (row_reg != '1) row_next = row_reg + ROW_W'(1);
        end
        emit = (kw_sat >= KDIM_W'(2)) && (kh_sat >= KDIM_W'(2))
            && (CMP_W'(col_reg) >= CMP_W'(kw_sat - KDIM_W'(1)))
            && (row_reg >= ROW_W'(kh_sat - KDIM_W'(1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: hold the accepted pixel while the line RAM is read
    // ------------------------------------------------------------------
    logic             a_valid_reg, a_emit_reg, a_fend_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [COL_W-1:0] a_x_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
        if (adv) begin
            a_emit_reg <= emit;
            a_fend_reg <= s_frame_end_in;
            a_pix_reg  <= {s_red_in, s_green_in, s_blue_in};
            a_x_reg    <= col_reg;
        end
    end

    // Line RAM: one word holds the column of earlier rows at one x
    logic              line_wr;
    logic [LINE_W-1:0] line_rd, line_wdata, line_col, byp_data_reg;
    logic              byp_reg;

    assign line_wr = adv && a_valid_reg;

    rgbwc_ram #(
        .WIDTH(LINE_W),
        .DEPTH(MAX_IMAGE_WIDTH)
    ) u_line_ram (
        .aclk    (aclk),
        .wr_en   (line_wr),
        .wr_addr (a_x_reg),
        .wr_data (line_wdata),
        .rd_en   (adv),
        .rd_addr (col_reg),
        .rd_data (line_rd)
    );

    // Forward a write that lands on the address being read in the same cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else if (adv) begin
            byp_reg <= line_wr && (a_x_reg == col_reg);
        end
        if (adv) begin
            byp_data_reg <= line_wdata;
        end
    end

    assign line_col = byp_reg ? byp_data_reg : line_rd;

    // Push the new pixel in at the lowest slot; oldest row falls out
    generate
        if (MAX_KERNEL > 2) begin : g_line_shift
            assign line_wdata = {line_col[LINE_W-PIX_W-1:0], a_pix_reg};
        end else begin : g_line_single
            assign line_wdata = a_pix_reg;
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage B: window cell chain, then per-cell products
    // ------------------------------------------------------------------
    rgbwc_pkg::cell_ctrl_t cell_ctrl;

    assign cell_ctrl.shift   = adv && a_valid_reg;
    assign cell_ctrl.advance = adv;

    logic [PIX_W-1:0]         win_pix [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] pr [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] pg [MAX_KERNEL][MAX_KERNEL];
    logic signed [PROD_W-1:0] pb [MAX_KERNEL][MAX_KERNEL];

    generate
        for (genvar u = 0; u < MAX_KERNEL; u++) begin : g_row
            for (genvar v = 0; v < MAX_KERNEL; v++) begin : g_col
                logic [PIX_W-1:0]         cell_in;
                logic signed [COEF_W-1:0] cell_w;
                logic [KDIM_W-1:0]        wr_i, wc_i;

                // u rows up and v columns back pair with kernel (kh-1-u, kw-1-v)
                always_comb begin
                    wr_i   = kh_sat - KDIM_W'(u) - KDIM_W'(1);
                    wc_i   = kw_sat - KDIM_W'(v) - KDIM_W'(1);
                    cell_w = '0;
                    if ((KDIM_W'(u) < kh_sat) && (KDIM_W'(v) < kw_sat)) begin
                        cell_w = coef_reg[wr_i[KI_W-1:0]][COEF_W*wc_i +: COEF_W];
                    end
                end

                if (v == 0) begin : g_feed
                    if (u == 0) begin : g_top
                        assign cell_in = a_pix_reg;
                    end else begin : g_line
                        assign cell_in = line_col[PIX_W*(u-1) +: PIX_W];
                    end
                end else begin : g_chain
                    assign cell_in = win_pix[u][v-1];
                end

                rgbwc_cell u_cell (
                    .aclk    (aclk),
                    .ctrl    (cell_ctrl),
                    .pix_in  (cell_in),
                    .weight  (cell_w),
                    .pix_out (win_pix[u][v]),
                    .prod_r  (pr[u][v]),
                    .prod_g  (pg[u][v]),
                    .prod_b  (pb[u][v])
                );
            end
        end
    endgenerate

    logic b_vld_reg, b_fend_reg, c_vld_reg, c_fend_reg, d_vld_reg, d_fend_reg;

    // ------------------------------------------------------------------
    // Stage D: per-row sums; output: total, floor and clamp
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] rs_r_reg [MAX_KERNEL];
    logic signed [SUM_W-1:0] rs_g_reg [MAX_KERNEL];
    logic signed [SUM_W-1:0] rs_b_reg [MAX_KERNEL];
    logic signed [SUM_W-1:0] rs_r_next [MAX_KERNEL];
    logic signed [SUM_W-1:0] rs_g_next [MAX_KERNEL];
    logic signed [SUM_W-1:0] rs_b_next [MAX_KERNEL];

    // Only cells inside the kernel in use contribute; the others may hold
    // pixels that were never written
    always_comb begin
        for (int u = 0; u < MAX_KERNEL; u++) begin
            rs_r_next[u] = '0;
            rs_g_next[u] = '0;
            rs_b_next[u] = '0;
            for (int v = 0; v < MAX_KERNEL; v++) begin
                if ((KDIM_W'(u) < kh_sat) && (KDIM_W'(v) < kw_sat)) begin
                    rs_r_next[u] = rs_r_next[u] + SUM_W'(pr[u][v]);
                    rs_g_next[u] = rs_g_next[u] + SUM_W'(pg[u][v]);
                    rs_b_next[u] = rs_b_next[u] + SUM_W'(pb[u][v]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int u = 0; u < MAX_KERNEL; u++) begin
                rs_r_reg[u] <= rs_r_next[u];
                rs_g_reg[u] <= rs_g_next[u];
                rs_b_reg[u] <= rs_b_next[u];
            end
        end
    end

    function automatic logic [CH_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-1:0] v;
        v = SUM_W'(s >>> COEF_FRAC_BITS);
        if (s < 0) return '0;
        if (v > SUM_W'(rgbwc_pkg::CH_MAX)) return rgbwc_pkg::CH_MAX;
        return v[CH_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] tot_r, tot_g, tot_b;

    always_comb begin
        tot_r = '0;
        tot_g = '0;
        tot_b = '0;
        for (int u = 0; u < MAX_KERNEL; u++) begin
            tot_r = tot_r + rs_r_reg[u];
            tot_g = tot_g + rs_g_reg[u];
            tot_b = tot_b + rs_b_reg[u];
        end
    end

    logic            m_valid_reg, m_fend_reg;
    logic [CH_W-1:0] m_r_reg, m_g_reg, m_b_reg;

    // Valid and frame-end flags travel beside the data stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            d_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            b_vld_reg   <= a_valid_reg && a_emit_reg;
            c_vld_reg   <= b_vld_reg;
            d_vld_reg   <= c_vld_reg;
            m_valid_reg <= d_vld_reg;
        end
        if (adv) begin
            b_fend_reg <= a_fend_reg;
            c_fend_reg <= b_fend_reg;
            d_fend_reg <= c_fend_reg;
            m_fend_reg <= d_fend_reg;
            m_r_reg    <= clamp_ch(tot_r);
            m_g_reg    <= clamp_ch(tot_g);
            m_b_reg    <= clamp_ch(tot_b);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_red_out       = m_r_reg;
    assign m_green_out     = m_g_reg;
    assign m_blue_out      = m_b_reg;
    assign m_frame_end_out = m_fend_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready with empty output register");

    a_stage_a_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && !adv) |=> (a_valid_reg && $stable(a_x_reg)))
        else $error("stage A lost its pixel during a stall");

    a_frame_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_frame_end_in) |=> (col_reg == '0 && row_reg == '0))
        else $error("counters not cleared after frame end");

endmodule

// ----- bench/rgb_window_convolution_tb.sv -----
`timescale 1ns / 1ps

module rgb_window_convolution_tb;

    localparam int STALL_LIMIT = 4000;   // cycles without any handshake or write
    localparam int SETTLE      = 12;     // pipeline is five deep; give it margin
    localparam int HOLD_OFF    = 400;    // long receiver hold-off, in cycles
    localparam int RANDOM_REQS = 900;

    localparam int CH_W            = rgbwc_pkg::CH_W;
    localparam int PIX_W           = rgbwc_pkg::PIX_W;
    localparam int COEF_W          = rgbwc_pkg::COEF_W;
    localparam int CFG_W           = rgbwc_pkg::CFG_W;
    localparam int IDX_W           = rgbwc_pkg::IDX_W;
    localparam int KDIM_W          = rgbwc_pkg::KDIM_W;
    localparam int IMGW_W          = rgbwc_pkg::IMGW_W;
    localparam int MAX_KERNEL      = rgbwc_pkg::MAX_KERNEL;
    localparam int MAX_IMAGE_WIDTH = rgbwc_pkg::MAX_IMAGE_WIDTH;
    localparam int COEF_FRAC_BITS  = rgbwc_pkg::COEF_FRAC_BITS;

    localparam logic [IDX_W-1:0] REG_ORDER [8] = '{
        rgbwc_pkg::REG_KERNEL_WIDTH, rgbwc_pkg::REG_KERNEL_HEIGHT,
        rgbwc_pkg::REG_IMAGE_WIDTH, rgbwc_pkg::REG_COEF_ROW0,
        rgbwc_pkg::REG_COEF_ROW1, rgbwc_pkg::REG_COEF_ROW2,
        rgbwc_pkg::REG_COEF_ROW3, rgbwc_pkg::REG_COEF_ROW4
    };

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            fe;
    } conv_px_t;

    typedef enum int {PIX_NOISE, PIX_EXTREME} pix_style_t;

    // Convolution predictor plus the queue of pixels it has promised.
    class conv_scoreboard;
        logic [KDIM_W-1:0] kw_reg, kh_reg;
        logic [IMGW_W-1:0] width_reg;
        logic [CFG_W-1:0]  coef [MAX_KERNEL];
        logic [PIX_W-1:0]  lines [MAX_KERNEL-1][MAX_IMAGE_WIDTH];
        logic [PIX_W-1:0]  win [MAX_KERNEL][MAX_KERNEL];
        int unsigned       col, row;
        conv_px_t          pending_q [$];
        int                mismatches, results, requests;

        function new();
            kw_reg    = rgbwc_pkg::KERNEL_DIM_RESET;
            kh_reg    = rgbwc_pkg::KERNEL_DIM_RESET;
            width_reg = rgbwc_pkg::IMAGE_WIDTH_RESET;
            foreach (coef[i]) coef[i] = '0;
            coef[1] = rgbwc_pkg::COEF_ROW1_RESET;
            col = 0;
            row = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                rgbwc_pkg::REG_KERNEL_WIDTH:  kw_reg = v[KDIM_W-1:0];
                rgbwc_pkg::REG_KERNEL_HEIGHT: kh_reg = v[KDIM_W-1:0];
                rgbwc_pkg::REG_IMAGE_WIDTH:   width_reg = v[IMGW_W-1:0];
                default:           coef[idx - rgbwc_pkg::REG_COEF_ROW0] = v;
            endcase
        endfunction

        function logic [CH_W-1:0] clamp(longint s);
            longint v;
            if (s < 0) return '0;
            v = s >>> COEF_FRAC_BITS;
            return (v > 255) ? rgbwc_pkg::CH_MAX : v[CH_W-1:0];
        endfunction

        function void note_request(conv_px_t px);
            logic [PIX_W-1:0]  column [MAX_KERNEL];
            logic [PIX_W-1:0]  p;
            logic signed [COEF_W-1:0] wt;
            int unsigned kw, kh, w, x;
            longint sr, sg, sb;
            conv_px_t e;
            requests++;
            kw = (kw_reg > MAX_KERNEL) ? MAX_KERNEL : kw_reg;
            kh = (kh_reg > MAX_KERNEL) ? MAX_KERNEL : kh_reg;
            w  = (width_reg < 2) ? 2 : (width_reg > MAX_IMAGE_WIDTH) ? MAX_IMAGE_WIDTH
                                                                    : width_reg;
            x  = col % MAX_IMAGE_WIDTH;
            column[0] = {px.red, px.green, px.blue};
            for (int r = 1; r < MAX_KERNEL; r++) column[r] = lines[r-1][x];
            for (int r = MAX_KERNEL - 1; r > 0; r--) lines[r-1][x] = column[r-1];
            for (int r = 0; r < MAX_KERNEL; r++) begin
                for (int c = MAX_KERNEL - 1; c > 0; c--) win[r][c] = win[r][c-1];
                win[r][0] = column[r];
            end
            if (kw >= 2 && kh >= 2 && col >= kw - 1 && row >= kh - 1) begin
                sr = 0; sg = 0; sb = 0;
                for (int r = 0; r < kh; r++) begin
                    for (int c = 0; c < kw; c++) begin
                        p  = win[kh-1-r][kw-1-c];
                        wt = coef[r][COEF_W*c +: COEF_W];
                        sr += longint'(p[23:16]) * longint'(wt);
                        sg += longint'(p[15:8])  * longint'(wt);
                        sb += longint'(p[7:0])   * longint'(wt);
                    end
                end
                e.red   = clamp(sr);
                e.green = clamp(sg);
                e.blue  = clamp(sb);
                e.fe    = px.fe;
                pending_q.insert(pending_q.size(), e);
            end
            // advance raster position; the marked pixel closes the frame
            if (px.fe) begin
                col = 0;
                row = 0;
            end else begin
                col++;
                if (col >= w) begin
                    col = 0;
                    if (row < 65535) row++;
                end
            end
        endfunction

        function void check_result(conv_px_t got);
            conv_px_t e;
            results++;
            if (pending_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected pixel %h/%h/%h fe=%0b", $realtime,
                             got.red, got.green, got.blue, got.fe);
                return;
            end
            e = pending_q.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: pixel %0d expected %h/%h/%h fe=%0b, got %h/%h/%h fe=%0b",
                             $realtime, results, e.red, e.green, e.blue, e.fe,
                             got.red, got.green, got.blue, got.fe);
            end
        endfunction
    endclass

    logic                aclk, aresetn;
    logic                s_valid, s_ready, s_frame_end_in;
    logic [CH_W-1:0]     s_red_in, s_green_in, s_blue_in;
    logic                m_valid, m_ready, m_frame_end_out;
    logic [CH_W-1:0]     m_red_out, m_green_out, m_blue_out;
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;

    conv_scoreboard sb = new();

    int burst_left, quiet_bursts;
    int hold_kicks, hold_seen, hold_left, rx_mode, rx_left, rx_cyc;
    int stall_cycles, config_sets;

    rgb_window_convolution u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_red_in       (s_red_in),
        .s_green_in     (s_green_in),
        .s_blue_in      (s_blue_in),
        .s_frame_end_in (s_frame_end_in),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_red_out      (m_red_out),
        .m_green_out    (m_green_out),
        .m_blue_out     (m_blue_out),
        .m_frame_end_out(m_frame_end_out),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Note every accepted request and check every accepted result at the edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_request('{s_red_in, s_green_in, s_blue_in, s_frame_end_in});
        if (aresetn && m_valid && m_ready)
            sb.check_result('{m_red_out, m_green_out, m_blue_out, m_frame_end_out});
    end

    // Receiver: stall on a changing pattern; honour a long hold-off when kicked.
    always @(posedge aclk) begin
        rx_cyc++;
        if (hold_kicks != hold_seen) begin
            hold_seen = hold_kicks;
            hold_left = HOLD_OFF;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(16, 128);
            end
            rx_left--;
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((rx_cyc % 8) < 5);
            endcase
        end
    end

    // Watchdog: drop the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one pixel request and hold it until accepted; gaps fall between bursts.
    task automatic send_pixel(logic [PIX_W-1:0] pix, logic fe);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = (quiet_bursts > 0) ? 0 : $urandom_range(0, 6);
            if (quiet_bursts > 0) quiet_bursts--;
            else if ($urandom_range(0, 15) == 0) quiet_bursts = $urandom_range(2, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid        <= 1'b1;
        s_red_in       <= pix[23:16];
        s_green_in     <= pix[15:8];
        s_blue_in      <= pix[7:0];
        s_frame_end_in <= fe;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [PIX_W-1:0] make_pixel(pix_style_t style);
        logic [PIX_W-1:0] p;
        p = PIX_W'($urandom);
        if (style == PIX_EXTREME)
            for (int ch = 0; ch < 3; ch++)
                case ($urandom_range(0, 2))
                    0:       p[8*ch +: 8] = 8'h00;
                    1:       p[8*ch +: 8] = 8'hFF;
                    default: ;
                endcase
        return p;
    endfunction

    task automatic send_frame(int len, pix_style_t style);
        for (int i = 0; i < len; i++)
            send_pixel(make_pixel(style), i == len - 1);
    endtask

    // Drop valid, then wait for every expected pixel plus the pipeline depth.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write all eight registers; unused upper bits carry noise.
    task automatic load_config(int kw, int kh, int w, logic [CFG_W-1:0] c [MAX_KERNEL]);
        logic [63:0]      junk;
        logic [CFG_W-1:0] d;
        settle();
        for (int i = 0; i < 8; i++) begin
            junk = {$urandom, $urandom};
            d    = junk[CFG_W-1:0];
            case (REG_ORDER[i])
                rgbwc_pkg::REG_KERNEL_WIDTH:  d[KDIM_W-1:0] = KDIM_W'(kw);
                rgbwc_pkg::REG_KERNEL_HEIGHT: d[KDIM_W-1:0] = KDIM_W'(kh);
                rgbwc_pkg::REG_IMAGE_WIDTH:   d[IMGW_W-1:0] = IMGW_W'(w);
                default:           d = c[REG_ORDER[i] - rgbwc_pkg::REG_COEF_ROW0];
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= d;
            @(posedge aclk);
            sb.write_reg(REG_ORDER[i], d);
        end
        cfg_wr_en <= 1'b0;
        config_sets++;
    endtask

    task automatic fill_coefs(logic [COEF_W-1:0] wt, output logic [CFG_W-1:0] c [MAX_KERNEL]);
        for (int r = 0; r < MAX_KERNEL; r++)
            c[r] = {MAX_KERNEL{wt}};
    endtask

    // Mix of gentle weights, wild weights and the two extremes.
    task automatic random_coefs(output logic [CFG_W-1:0] c [MAX_KERNEL]);
        int mode;
        int v;
        mode = $urandom_range(0, 3);
        for (int r = 0; r < MAX_KERNEL; r++)
            for (int j = 0; j < MAX_KERNEL; j++) begin
                case (mode)
                    0:       v = $urandom_range(0, 160) - 64;
                    1:       v = $urandom;
                    2:       v = ($urandom_range(0, 1)) ? 12'h7FF : 12'h800;
                    default: v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 80);
                endcase
                c[r][COEF_W*j +: COEF_W] = v[COEF_W-1:0];
            end
    endtask

    initial begin
        logic [CFG_W-1:0] c [MAX_KERNEL];
        int kw, kh, w, len;

        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_red_in       <= '0;
        s_green_in     <= '0;
        s_blue_in      <= '0;
        s_frame_end_in <= 1'b0;
        m_ready        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= rgbwc_pkg::REG_KERNEL_WIDTH;
        cfg_wdata      <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: 3x3 over 640-wide rows; a short frame stays silent.
        send_frame(40, PIX_NOISE);

        // Largest weights saturate high; frames shorter than the kernel stay silent.
        fill_coefs(12'h7FF, c);
        load_config(2, 2, 2, c);
        send_frame(1, PIX_EXTREME);
        send_frame(3, PIX_EXTREME);
        send_frame(6, PIX_EXTREME);

        // Most negative weights clamp to zero; full 5x5 window.
        fill_coefs(12'h800, c);
        load_config(5, 5, 5, c);
        send_frame(25, PIX_EXTREME);

        // Kernel dimensions of zero and one produce nothing.
        random_coefs(c);
        load_config(0, 3, 4, c);
        send_frame(12, PIX_NOISE);
        load_config(3, 1, 4, c);
        send_frame(12, PIX_NOISE);

        // Oversized kernel and undersized width both saturate.
        load_config(7, 6, 1, c);
        send_frame(12, PIX_NOISE);
        load_config(6, 7, 0, c);
        send_frame(12, PIX_NOISE);

        // Width beyond the maximum saturates to the full line.
        random_coefs(c);
        load_config(2, 2, 4095, c);
        send_frame(24, PIX_NOISE);

        // Long receiver hold-off while a dense 2x2 stream keeps offering pixels.
        random_coefs(c);
        load_config(2, 2, 8, c);
        hold_kicks++;
        send_frame(200, PIX_NOISE);

        // Random settings and frames.
        len = sb.requests + RANDOM_REQS;
        while (sb.requests < len) begin
            kw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 5);
            kh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 5);
            w  = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 48) : $urandom_range(2, 24);
            random_coefs(c);
            load_config(kw, kh, w, c);
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 4) == 0)
                    send_frame($urandom_range(1, 5 * w), PIX_EXTREME);
                else
                    send_frame($urandom_range(5 * w, 8 * w), PIX_NOISE);
            end
        end

        settle();
        $display("%0d pixel requests over %0d register sets, %0d result pixels checked",
                 sb.requests, config_sets, sb.results);
        $display("kernel/width extremes, clamping, short frames and a long hold-off covered");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.pending_q.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
